// ----- rtl/core/adll_pkg.sv -----
// shared types and constants of the array based doubly linked list
package adll_pkg;

    localparam int SLOTS  = 16;
    localparam int SLOT_W = 4;
    localparam int LINK_W = 5;
    localparam int DATA_W = 32;
    localparam int OP_W   = 2;
    localparam int STAT_W = 2;

    // link code that means no slot
    localparam logic [LINK_W-1:0] NONE_LINK = LINK_W'(SLOTS);

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_READ   = 2'd2
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_LINK,
        S_DONE
    } t_state;

    // one port set of a slot memory
    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic              re;
        logic [SLOT_W-1:0] raddr;
    } t_ram_ctl;

    function automatic logic link_ok(input logic [LINK_W-1:0] l);
        return l < LINK_W'(SLOTS);
    endfunction

endpackage

// ----- rtl/core/adll_in_if.sv -----
// request channel: operation, value and slot index
interface adll_in_if;
    import adll_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          operation;
    logic signed [DATA_W-1:0] value;
    logic [SLOT_W-1:0]        slot_index;

    modport source (output valid, output operation, output value, output slot_index,
                    input ready);
    modport sink   (input valid, input operation, input value, input slot_index,
                    output ready);
endinterface

// ----- rtl/core/adll_out_if.sv -----
// response channel: status, slot, read data and list heads
interface adll_out_if;
    import adll_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        status;
    logic [SLOT_W-1:0]        slot_used;
    logic signed [DATA_W-1:0] read_value;
    logic [LINK_W-1:0]        read_next;
    logic [LINK_W-1:0]        read_prev;
    logic [LINK_W-1:0]        list_head;
    logic [LINK_W-1:0]        free_head;

    modport source (output valid, output status, output slot_used, output read_value,
                    output read_next, output read_prev, output list_head,
                    output free_head, input ready);
    modport sink   (input valid, input status, input slot_used, input read_value,
                    input read_next, input read_prev, input list_head,
                    input free_head, output ready);
endinterface

// ----- rtl/core/adll_ram.sv -----
// slot memory: one write port, one registered read port, read before write
module adll_ram #(
    parameter int WIDTH = 32
) (
    input  logic                 i_clk,
    input  adll_pkg::t_ram_ctl   i_ctl,
    input  logic [WIDTH-1:0]     i_wdata,
    output logic [WIDTH-1:0]     o_rdata
);
    import adll_pkg::*;

    logic [WIDTH-1:0] r_mem [SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_ctl.waddr] <= i_wdata;
        end
        if (i_ctl.re) begin
            o_rdata <= r_mem[i_ctl.raddr];
        end
    end
endmodule

// ----- rtl/core/array_doubly_linked_list.sv -----
// top level of the array based doubly linked list with free list
//
//  channel  | dir | handshake         | payload
//  i_req    | in  | valid / ready     | operation, value, slot_index
//  o_rsp    | out | valid / ready     | status, slot_used, read_value, read_next,
//           |     |                   | read_prev, list_head, free_head
//
// an item goes from acceptance to its response in the output register in steps:
// accept (first reads and writes), link fix-up, finish; the single write port of the
// prev link memory sets these steps. the next item is accepted after the finish step.
// after reset a clearing pass writes every slot of the memories; no item is taken then.
// a stalled output holds the finish step; an unread response does not block acceptance.
module array_doubly_linked_list (
    input  logic          i_clk,
    input  logic          i_rst_n,
    adll_in_if.sink       i_req,
    adll_out_if.source    o_rsp
);
    import adll_pkg::*;

    t_state             r_state, n_state;
    logic [SLOT_W-1:0]  r_init_cnt, n_init_cnt;
    logic [LINK_W-1:0]  r_head, n_head;
    logic [LINK_W-1:0]  r_free, n_free;
    logic               r_act, n_act;
    logic [OP_W-1:0]    r_op, n_op;
    logic [SLOT_W-1:0]  r_idx, n_idx;

    logic               r_out_valid, n_out_valid;
    t_status            r_status, n_status;
    logic [SLOT_W-1:0]  r_used, n_used;
    logic [DATA_W-1:0]  r_rval, n_rval;
    logic [LINK_W-1:0]  r_rnext, n_rnext;
    logic [LINK_W-1:0]  r_rprev, n_rprev;
    logic [LINK_W-1:0]  r_lhead, n_lhead;
    logic [LINK_W-1:0]  r_fhead, n_fhead;

    t_ram_ctl           data_ctl, next_ctl, prev_ctl;
    logic [DATA_W-1:0]  data_wd, data_rd;
    logic [LINK_W-1:0]  next_wd, next_rd;
    logic [LINK_W-1:0]  prev_wd, prev_rd;

    logic               accept;
    logic               out_free;
    logic [LINK_W-1:0]  idx_l;
    logic [SLOT_W-1:0]  free_s;

    adll_ram #(.WIDTH(DATA_W)) u_data (
        .i_clk   (i_clk),
        .i_ctl   (data_ctl),
        .i_wdata (data_wd),
        .o_rdata (data_rd)
    );

    adll_ram #(.WIDTH(LINK_W)) u_next (
        .i_clk   (i_clk),
        .i_ctl   (next_ctl),
        .i_wdata (next_wd),
        .o_rdata (next_rd)
    );

    adll_ram #(.WIDTH(LINK_W)) u_prev (
        .i_clk   (i_clk),
        .i_ctl   (prev_ctl),
        .i_wdata (prev_wd),
        .o_rdata (prev_rd)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign idx_l       = LINK_W'(r_idx);
    assign free_s      = r_free[SLOT_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_init_cnt  = r_init_cnt;
        n_head      = r_head;
        n_free      = r_free;
        n_act       = r_act;
        n_op        = r_op;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_status    = r_status;
        n_used      = r_used;
        n_rval      = r_rval;
        n_rnext     = r_rnext;
        n_rprev     = r_rprev;
        n_lhead     = r_lhead;
        n_fhead     = r_fhead;
        data_ctl    = '0;
        next_ctl    = '0;
        prev_ctl    = '0;
        data_wd     = '0;
        next_wd     = '0;
        prev_wd     = '0;

        unique case (r_state)
            S_INIT: begin
                data_ctl.we    = 1'b1;
                data_ctl.waddr = r_init_cnt;
                next_ctl.we    = 1'b1;
                next_ctl.waddr = r_init_cnt;
                next_wd        = (r_init_cnt == SLOT_W'(SLOTS - 1)) ? NONE_LINK
                               : LINK_W'(r_init_cnt) + LINK_W'(1);
                prev_ctl.we    = 1'b1;
                prev_ctl.waddr = r_init_cnt;
                prev_wd        = (r_init_cnt == '0) ? NONE_LINK
                               : LINK_W'(r_init_cnt) - LINK_W'(1);
                if (r_init_cnt == SLOT_W'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_init_cnt = r_init_cnt + SLOT_W'(1);
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_op    = i_req.operation;
                    n_idx   = i_req.slot_index;
                    n_state = S_LINK;
                    data_ctl.re    = 1'b1;
                    next_ctl.re    = 1'b1;
                    prev_ctl.re    = 1'b1;
                    data_ctl.raddr = i_req.slot_index;
                    next_ctl.raddr = i_req.slot_index;
                    prev_ctl.raddr = i_req.slot_index;
                    case (i_req.operation)
                        OP_INSERT: begin
                            n_act          = link_ok(r_free);
                            data_ctl.raddr = free_s;
                            next_ctl.raddr = free_s;
                            prev_ctl.raddr = free_s;
                            // new slot: store value, link to old head, no prev
                            data_ctl.we    = n_act;
                            data_ctl.waddr = free_s;
                            data_wd        = i_req.value;
                            next_ctl.we    = n_act;
                            next_ctl.waddr = free_s;
                            next_wd        = r_head;
                            prev_ctl.we    = n_act;
                            prev_ctl.waddr = free_s;
                            prev_wd        = NONE_LINK;
                        end
                        OP_DELETE: begin
                            n_act          = (r_head != NONE_LINK);
                            // read sees old links, later fix-ups skip this slot
                            next_ctl.we    = n_act;
                            next_ctl.waddr = i_req.slot_index;
                            next_wd        = r_free;
                            prev_ctl.we    = n_act;
                            prev_ctl.waddr = i_req.slot_index;
                            prev_wd        = NONE_LINK;
                        end
                        default: begin
                            n_act = 1'b0;
                        end
                    endcase
                end
            end
            S_LINK: begin
                n_state = S_DONE;
                if (r_act) begin
                    case (r_op)
                        OP_INSERT: begin
                            // new free head loses its prev link
                            prev_ctl.we    = link_ok(next_rd);
                            prev_ctl.waddr = next_rd[SLOT_W-1:0];
                            prev_wd        = NONE_LINK;
                        end
                        OP_DELETE: begin
                            next_ctl.we    = (r_head != idx_l) && link_ok(prev_rd)
                                             && (prev_rd != idx_l);
                            next_ctl.waddr = prev_rd[SLOT_W-1:0];
                            next_wd        = next_rd;
                            // skipped where a later write lands on the same slot
                            prev_ctl.we    = link_ok(next_rd) && (next_rd != idx_l)
                                             && (next_rd != r_free);
                            prev_ctl.waddr = next_rd[SLOT_W-1:0];
                            prev_wd        = prev_rd;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_status    = ST_OK;
                    n_used      = r_idx;
                    n_rval      = '0;
                    n_rnext     = '0;
                    n_rprev     = '0;
                    case (r_op)
                        OP_INSERT: begin
                            if (r_act) begin
                                prev_ctl.we    = link_ok(r_head);
                                prev_ctl.waddr = r_head[SLOT_W-1:0];
                                prev_wd        = r_free;
                                n_free         = next_rd;
                                n_head         = r_free;
                                n_used         = free_s;
                            end else begin
                                n_status = ST_FULL;
                            end
                        end
                        OP_DELETE: begin
                            if (r_act) begin
                                prev_ctl.we    = link_ok(r_free);
                                prev_ctl.waddr = free_s;
                                prev_wd        = idx_l;
                                n_head         = (r_head == idx_l) ? next_rd : r_head;
                                n_free         = idx_l;
                            end else begin
                                n_status = ST_EMPTY;
                            end
                        end
                        OP_READ: begin
                            n_rval  = data_rd;
                            n_rnext = next_rd;
                            n_rprev = prev_rd;
                        end
                        default: begin
                        end
                    endcase
                    n_lhead = n_head;
                    n_fhead = n_free;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_init_cnt  <= '0;
            r_head      <= NONE_LINK;
            r_free      <= '0;
            r_act       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init_cnt  <= n_init_cnt;
            r_head      <= n_head;
            r_free      <= n_free;
            r_act       <= n_act;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_used   <= n_used;
        r_rval   <= n_rval;
        r_rnext  <= n_rnext;
        r_rprev  <= n_rprev;
        r_lhead  <= n_lhead;
        r_fhead  <= n_fhead;
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_status;
    assign o_rsp.slot_used  = r_used;
    assign o_rsp.read_value = r_rval;
    assign o_rsp.read_next  = r_rnext;
    assign o_rsp.read_prev  = r_rprev;
    assign o_rsp.list_head  = r_lhead;
    assign o_rsp.free_head  = r_fhead;
endmodule

// ----- rtl/core/adll_chk.sv -----
// port level checks of the linked list block and their bind
module adll_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [adll_pkg::STAT_W-1:0]   i_status,
    input logic [adll_pkg::SLOT_W-1:0]   i_slot_used,
    input logic [adll_pkg::DATA_W-1:0]   i_read_value,
    input logic [adll_pkg::LINK_W-1:0]   i_read_next,
    input logic [adll_pkg::LINK_W-1:0]   i_read_prev,
    input logic [adll_pkg::LINK_W-1:0]   i_list_head,
    input logic [adll_pkg::LINK_W-1:0]   i_free_head
);
    import adll_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    // a waiting response keeps its contents
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_status)
            && $stable(i_slot_used) && $stable(i_read_value) && $stable(i_read_next)
            && $stable(i_read_prev) && $stable(i_list_head) && $stable(i_free_head)))
        else $error("response changed while stalled");

    // one item at a time: ready drops right after an item is taken
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in_ready)
        else $error("item accepted while another is in work");

    // a response appearing on an empty output is checked against the acceptance of its item
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(in_acc, 3))
        else $error("response without matching item");

    a_full_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status == ST_FULL)) |-> (i_free_head == NONE_LINK))
        else $error("pool full reported with a free slot");

    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status == ST_EMPTY)) |-> (i_list_head == NONE_LINK))
        else $error("list empty reported with a live head");
endmodule

bind array_doubly_linked_list adll_chk u_adll_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_status     (o_rsp.status),
    .i_slot_used  (o_rsp.slot_used),
    .i_read_value (o_rsp.read_value),
    .i_read_next  (o_rsp.read_next),
    .i_read_prev  (o_rsp.read_prev),
    .i_list_head  (o_rsp.list_head),
    .i_free_head  (o_rsp.free_head)
);
